/* hdl/cdfp_pkg.sv */
// ----------------------------------------------------------------------------
// cdfp_pkg
// Shared widths, framing bytes and the result type of the decimal frame parser.
// ----------------------------------------------------------------------------
package cdfp_pkg;

  // Field widths
  localparam int unsigned ByteW   = 8;
  localparam int unsigned ValueW  = 54;
  localparam int unsigned CountW  = 5;
  localparam int unsigned OutDataW = 56;

  // Framing bytes
  localparam logic [ByteW-1:0] StartByte = 8'hF1;
  localparam logic [ByteW-1:0] EndByte   = 8'hF6;
  localparam logic [ByteW-1:0] DigitZero = 8'h30;
  localparam logic [ByteW-1:0] DigitNine = 8'h39;

  // Longest legal payload, in bytes
  localparam logic [ByteW-1:0] MaxPayload = 8'd16;

  // One parsed frame
  typedef struct packed {
    logic [ValueW-1:0] msg_value;
    logic [ByteW-1:0]  msg_type;
  } cdfp_result_t;

endpackage

/* hdl/checksummed_decimal_frame_parser_top.sv */
// ----------------------------------------------------------------------------
// checksummed_decimal_frame_parser_top
// Parses framed ASCII decimal messages with an additive checksum.
// ----------------------------------------------------------------------------
// Takes one received byte per item and accepts a new byte every clock cycle
// while the result side is not stalled. Each byte waits in the input register
// and is folded into the frame state at the edge where it leaves; a good frame
// is loaded into the result register at that same edge, so its result becomes
// valid as the end byte leaves the input register. A frame is F1, type,
// length (1..16), that many ASCII digits with the first digit least
// significant, a checksum (sum modulo 256 of all earlier frame bytes) and F6.
// The value travels on tdata and the type byte on tuser. Bad length, non-digit
// payload, wrong checksum or wrong end byte drop the frame without a result.
// Input readiness follows the output tready through combinational logic.
module checksummed_decimal_frame_parser_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  input  logic [cdfp_pkg::ByteW-1:0]    s_axis_tdata_i,   // [7:0] rx_byte
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  output logic [cdfp_pkg::OutDataW-1:0] m_axis_tdata_o,   // [53:0] msg_value
  output logic [cdfp_pkg::ByteW-1:0]    m_axis_tuser_o    // [7:0] msg_type
);
  import cdfp_pkg::*;

  logic             item_valid;
  logic [ByteW-1:0] item_byte;
  logic             out_free;
  logic             step;
  logic             res_valid;
  cdfp_result_t     res;

  // Move a byte into the parser only when the result register has room
  assign step = item_valid && out_free;

  cdfp_in_stage u_in_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_valid_i    (s_axis_tvalid_i),
    .s_data_i     (s_axis_tdata_i),
    .s_ready_o    (s_axis_tready_o),
    .take_i       (step),
    .item_valid_o (item_valid),
    .item_byte_o  (item_byte)
  );

  cdfp_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .byte_i      (item_byte),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  cdfp_out_stage u_out_stage (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .load_i    (res_valid),
    .res_i     (res),
    .m_ready_i (m_axis_tready_i),
    .m_valid_o (m_axis_tvalid_o),
    .m_data_o  (m_axis_tdata_o),
    .m_user_o  (m_axis_tuser_o),
    .free_o    (out_free)
  );

endmodule

/* hdl/cdfp_in_stage.sv */
// ----------------------------------------------------------------------------
// cdfp_in_stage
// Input register: captures one received byte and holds it until the parser
// takes it.
// ----------------------------------------------------------------------------
module cdfp_in_stage (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      s_valid_i,
  input  logic [cdfp_pkg::ByteW-1:0] s_data_i,
  output logic                      s_ready_o,
  input  logic                      take_i,
  output logic                      item_valid_o,
  output logic [cdfp_pkg::ByteW-1:0] item_byte_o
);
  import cdfp_pkg::*;

  logic             valid_q, valid_d;
  logic [ByteW-1:0] byte_q;
  logic             load;

  // Accept a new item when empty or when the held one moves on
  assign s_ready_o = !valid_q || take_i;
  assign load      = s_valid_i && s_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Hold the byte payload
  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q <= s_data_i;
    end
  end

  assign item_valid_o = valid_q;
  assign item_byte_o  = byte_q;

endmodule

/* hdl/cdfp_parser.sv */
// ----------------------------------------------------------------------------
// cdfp_parser
// Frame state machine: tracks start, type, length, payload digits, checksum
// and end byte, accumulating the decimal value one digit per byte.
// ----------------------------------------------------------------------------
module cdfp_parser (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       step_i,
  input  logic [cdfp_pkg::ByteW-1:0]  byte_i,
  output logic                       res_valid_o,
  output cdfp_pkg::cdfp_result_t     res_o
);
  import cdfp_pkg::*;

  localparam logic [2:0] StIdle    = 3'd0;
  localparam logic [2:0] StType    = 3'd1;
  localparam logic [2:0] StLen     = 3'd2;
  localparam logic [2:0] StPayload = 3'd3;
  localparam logic [2:0] StCsum    = 3'd4;
  localparam logic [2:0] StEnd     = 3'd5;

  logic [2:0]        state_q, state_d;
  logic [CountW-1:0] remain_q, remain_d;
  logic [ByteW-1:0]  type_q, type_d;
  logic [ByteW-1:0]  sum_q, sum_d;
  logic [ByteW-1:0]  sum_rx_q, sum_rx_d;
  logic [ValueW-1:0] accum_q, accum_d;
  logic [ValueW-1:0] weight_q, weight_d;
  logic              err_q, err_d;

  logic [ByteW-1:0]  sum_add;
  logic              is_digit;
  logic [ByteW-1:0]  digit_full;
  logic [3:0]        digit;
  logic [ValueW-1:0] term;
  logic [ValueW-1:0] weight_x10;

  assign sum_add    = sum_q + byte_i;
  assign is_digit   = (byte_i >= DigitZero) && (byte_i <= DigitNine);
  assign digit_full = byte_i - DigitZero;
  assign digit      = digit_full[3:0];

  // Digit times weight as four shifted copies of the weight
  assign term = ({ValueW{digit[0]}} & weight_q)
              + ({ValueW{digit[1]}} & (weight_q << 1))
              + ({ValueW{digit[2]}} & (weight_q << 2))
              + ({ValueW{digit[3]}} & (weight_q << 3));
  assign weight_x10 = (weight_q << 3) + (weight_q << 1);

  // Advance the frame state on each byte
  always_comb begin
    state_d     = state_q;
    remain_d    = remain_q;
    type_d      = type_q;
    sum_d       = sum_q;
    sum_rx_d    = sum_rx_q;
    accum_d     = accum_q;
    weight_d    = weight_q;
    err_d       = err_q;
    res_valid_o = 1'b0;
    if (step_i) begin
      unique case (state_q)
        StIdle: begin
          if (byte_i == StartByte) begin
            sum_d   = byte_i;
            state_d = StType;
          end
        end
        StType: begin
          type_d  = byte_i;
          sum_d   = sum_add;
          state_d = StLen;
        end
        StLen: begin
          if (byte_i == '0 || byte_i > MaxPayload) begin
            state_d = StIdle;
          end else begin
            remain_d = byte_i[CountW-1:0];
            sum_d    = sum_add;
            accum_d  = '0;
            weight_d = ValueW'(1);
            err_d    = 1'b0;
            state_d  = StPayload;
          end
        end
        StPayload: begin
          sum_d    = sum_add;
          if (is_digit) begin
            accum_d  = accum_q + term;
            weight_d = weight_x10;
          end else begin
            err_d = 1'b1;
          end
          remain_d = remain_q - CountW'(1);
          if (remain_q == CountW'(1)) begin
            state_d = StCsum;
          end
        end
        StCsum: begin
          sum_rx_d = byte_i;
          state_d  = StEnd;
        end
        StEnd: begin
          state_d     = StIdle;
          res_valid_o = (byte_i == EndByte) && (sum_rx_q == sum_q) && !err_q;
        end
        default: begin
          state_d = StIdle;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      remain_q <= '0;
      type_q   <= '0;
      sum_q    <= '0;
      sum_rx_q <= '0;
      accum_q  <= '0;
      weight_q <= ValueW'(1);
      err_q    <= 1'b0;
    end else begin
      state_q  <= state_d;
      remain_q <= remain_d;
      type_q   <= type_d;
      sum_q    <= sum_d;
      sum_rx_q <= sum_rx_d;
      accum_q  <= accum_d;
      weight_q <= weight_d;
      err_q    <= err_d;
    end
  end

  assign res_o.msg_type  = type_q;
  assign res_o.msg_value = accum_q;

endmodule

/* hdl/cdfp_out_stage.sv */
// ----------------------------------------------------------------------------
// cdfp_out_stage
// Result register: holds one parsed frame until the downstream side takes it.
// ----------------------------------------------------------------------------
module cdfp_out_stage (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          load_i,
  input  cdfp_pkg::cdfp_result_t        res_i,
  input  logic                          m_ready_i,
  output logic                          m_valid_o,
  output logic [cdfp_pkg::OutDataW-1:0] m_data_o,
  output logic [cdfp_pkg::ByteW-1:0]    m_user_o,
  output logic                          free_o
);
  import cdfp_pkg::*;

  logic         valid_q, valid_d;
  cdfp_result_t res_q;

  // Room for a new result when empty or when the held one leaves now
  assign free_o = !valid_q || m_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (m_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Hold the result payload
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign m_valid_o = valid_q;
  assign m_data_o  = {(OutDataW - ValueW)'(0), res_q.msg_value};
  assign m_user_o  = res_q.msg_type;

endmodule

/* hdl/cdfp_checker.sv */
// ----------------------------------------------------------------------------
// cdfp_checker
// Port-level checks of the decimal frame parser, bound to the top level.
// ----------------------------------------------------------------------------
module cdfp_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid_i,
  input logic                          s_axis_tready_o,
  input logic [cdfp_pkg::ByteW-1:0]    s_axis_tdata_i,
  input logic                          m_axis_tvalid_o,
  input logic                          m_axis_tready_i,
  input logic [cdfp_pkg::OutDataW-1:0] m_axis_tdata_o,
  input logic [cdfp_pkg::ByteW-1:0]    m_axis_tuser_o
);
  import cdfp_pkg::*;

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("stalled result changed");

  // Pad bits above the value stay zero
  a_out_pad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tdata_o[OutDataW-1:ValueW] == '0)
    else $error("result pad bits set");

  // Input never stalls while the result side is ready
  a_no_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tready_i |-> s_axis_tready_o)
    else $error("input stalled with output ready");

  // A fresh result must be preceded by an accepted end byte on the input
  a_end_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |->
      $past(s_axis_tvalid_i && s_axis_tready_o, 2) && $past(s_axis_tdata_i, 2) == EndByte)
    else $error("result without end byte");

endmodule

bind checksummed_decimal_frame_parser_top cdfp_checker u_cdfp_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .s_axis_tdata_i  (s_axis_tdata_i),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);
